### hdl/dhf_pkg.sv
// ----------------------------------------------------------------------------
// Decimating highpass / EMA channel filter package
// Sizes, register codes and shared types for the filter block.
// ----------------------------------------------------------------------------
package dhf_pkg;

   // Block sizing
   localparam int NUM_DEVICES  = 4;
   localparam int NUM_CHANNELS = 8;

   // Fixed field layout of the ports
   localparam int NUM_FIELD_CH = 8;
   localparam int DEV_W        = 2;
   localparam int SMP_W        = 24;
   localparam int OUT_W        = 32;
   localparam int REQ_DATA_W   = NUM_FIELD_CH * SMP_W;
   localparam int RSP_DATA_W   = NUM_FIELD_CH * OUT_W;

   // Arithmetic widths
   localparam int ST_W     = 48;   // Q32.16 filter state
   localparam int FRAC_W   = 16;
   localparam int COEF_W   = 32;   // Q2.30 coefficients
   localparam int DEC_W    = 16;
   localparam int ALPHA_W  = 31;
   localparam int MUL_S_W  = 50;   // multiplier sample operand
   localparam int MUL_R_W  = 52;   // rounded product
   localparam int ACC_W    = 54;

   // Derived index widths
   localparam int DEV_IDX_W   = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
   localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int MEM_DEPTH   = NUM_DEVICES * NUM_CHANNELS;
   localparam int MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int MEM_W       = 3 * ST_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_HP_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LP_ENABLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEC_FACTOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HP_B0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HP_B1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HP_A1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LP_ALPHA = 3'd6;

   typedef struct packed {
      logic                     hp_en;
      logic                     lp_en;
      logic [DEC_W-1:0]         dec_factor;
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] a1;
      logic [ALPHA_W-1:0]       alpha;
   } cfg_type;

   typedef logic signed [SMP_W-1:0] smp_type;

   typedef struct packed {
      logic [DEV_W-1:0]               device;
      smp_type [NUM_CHANNELS-1:0]     smp;
   } frame_type;

endpackage

### hdl/dhf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dhf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dhf_queue.sv
// ----------------------------------------------------------------------------
// Frame queue
// Short FIFO of kept frames between the decimation front end and the filter.
// ----------------------------------------------------------------------------
module dhf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dhf_pkg::frame_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output dhf_pkg::frame_type  out_data
);
   import dhf_pkg::*;

   frame_type         q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic [QCNT_W-1:0] cnt_in;
   logic              push;
   logic              pop;

   assign in_ready  = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### hdl/dhf_front.sv
// ----------------------------------------------------------------------------
// Decimation front end
// Takes input frames, runs the per-device frame counters and forwards the
// kept frames to the queue.
// ----------------------------------------------------------------------------
module dhf_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [dhf_pkg::DEC_W-1:0]       dec_factor,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dhf_pkg::DEV_W-1:0]       req_device,
   input  logic [dhf_pkg::REQ_DATA_W-1:0]  req_data,
   output logic                            push_valid,
   input  logic                            push_ready,
   output dhf_pkg::frame_type              push_data
);
   import dhf_pkg::*;

   logic [DEC_W-1:0]     cnt_ff [NUM_DEVICES];
   logic [DEC_W-1:0]     cnt_in;
   logic [DEV_IDX_W-1:0] dev_idx;
   logic                 dev_ok;
   logic                 keep;

   assign dev_ok  = (int'(req_device) < NUM_DEVICES);
   assign dev_idx = DEV_IDX_W'(req_device);
   assign cnt_in  = cnt_ff[dev_idx] + DEC_W'(1);

   // A factor of zero keeps every frame, the same as one.
   assign keep       = (cnt_in >= dec_factor);
   assign req_ready  = push_ready;
   assign push_valid = req_valid && dev_ok && keep;

   always_comb begin
      push_data.device = req_device;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         push_data.smp[k] = req_data[k*SMP_W +: SMP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DEVICES; d++) begin
            cnt_ff[d] <= '0;
         end
      end else if (req_valid && req_ready && dev_ok) begin
         cnt_ff[dev_idx] <= keep ? '0 : cnt_in;
      end
   end

endmodule

### hdl/dhf_mulq.sv
// ----------------------------------------------------------------------------
// Q2.30 coefficient multiplier
// Forms sample times coefficient exactly from two partial products and
// rounds the Q2.30 scaling away, ties to even; every step is registered.
// ----------------------------------------------------------------------------
module dhf_mulq (
   input  logic                                clock,
   input  logic signed [dhf_pkg::MUL_S_W-1:0]  s,
   input  logic signed [dhf_pkg::COEF_W-1:0]   c,
   output logic signed [dhf_pkg::MUL_R_W-1:0]  res
);
   import dhf_pkg::*;

   localparam int LO_W  = 24;
   localparam int HI_W  = MUL_S_W - LO_W;
   localparam int A_W   = HI_W + COEF_W;
   localparam int B_W   = LO_W + 1 + COEF_W;
   localparam int P_W   = A_W + LO_W;
   localparam int SHR   = 30;

   logic signed [HI_W-1:0]   sh;
   logic signed [LO_W:0]     sl;
   logic signed [A_W-1:0]    a_ff;
   logic signed [B_W-1:0]    b_ff;
   logic [P_W-1:0]           p_in;
   logic [P_W-1:0]           p_ff;
   logic [MUL_R_W-1:0]       q;
   logic [SHR-1:0]           r;
   logic                     inc;
   logic signed [MUL_R_W-1:0] res_ff;

   assign sh = s[MUL_S_W-1:LO_W];
   assign sl = $signed({1'b0, s[LO_W-1:0]});

   assign p_in = {a_ff, {LO_W{1'b0}}} + {{(P_W-B_W){b_ff[B_W-1]}}, b_ff};

   assign q   = p_ff[P_W-1:SHR];
   assign r   = p_ff[SHR-1:0];
   assign inc = (r > {1'b1, {(SHR-1){1'b0}}})
             || ((r == {1'b1, {(SHR-1){1'b0}}}) && q[0]);

   always_ff @(posedge clock) begin
      a_ff   <= sh * c;
      b_ff   <= sl * c;
      p_ff   <= p_in;
      res_ff <= $signed(q + MUL_R_W'(inc));
   end

   assign res = res_ff;

endmodule

### hdl/dhf_back.sv
// ----------------------------------------------------------------------------
// Filter back end
// Runs each channel of a kept frame through the highpass and the
// exponential lowpass on one shared multiplier, keeps the filter state in
// RAM and holds the finished result word for the output channel.
// ----------------------------------------------------------------------------
module dhf_back (
   input  logic                                      clock,
   input  logic                                      reset,
   input  dhf_pkg::cfg_type                          cfg,
   input  logic                                      fr_valid,
   output logic                                      fr_ready,
   input  dhf_pkg::frame_type                        fr_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [dhf_pkg::DEV_W-1:0]                 rsp_device,
   output logic [dhf_pkg::NUM_FIELD_CH-1:0][dhf_pkg::OUT_W-1:0] rsp_data
);
   import dhf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [3:0] PH_READ   = 4'd0;
   localparam logic [3:0] PH_MUL_B0 = 4'd1;
   localparam logic [3:0] PH_MUL_B1 = 4'd2;
   localparam logic [3:0] PH_MUL_A1 = 4'd3;
   localparam logic [3:0] PH_ACC_B0 = 4'd4;
   localparam logic [3:0] PH_ACC_B1 = 4'd5;
   localparam logic [3:0] PH_ACC_A1 = 4'd6;
   localparam logic [3:0] PH_SAT_HP = 4'd7;
   localparam logic [3:0] PH_DIFF   = 4'd8;
   localparam logic [3:0] PH_MUL_LP = 4'd9;
   localparam logic [3:0] PH_ACC_LP = 4'd12;
   localparam logic [3:0] PH_WRITE  = 4'd13;

   // RAM word layout: previous input, previous highpass, previous lowpass
   localparam int X_LSB = 2 * ST_W;
   localparam int Y_LSB = ST_W;

   function automatic logic [ST_W-1:0] sat48(input logic [ACC_W-1:0] v);
      if ((v[ACC_W-1:ST_W-1] == '0) || (v[ACC_W-1:ST_W-1] == '1)) begin
         return v[ST_W-1:0];
      end
      return v[ACC_W-1] ? {1'b1, {(ST_W-1){1'b0}}} : {1'b0, {(ST_W-1){1'b1}}};
   endfunction

   // Q32.16 to a count, ties to even; only the upper bound can be passed.
   function automatic logic [OUT_W-1:0] to_count(input logic [ST_W-1:0] v);
      logic [OUT_W-1:0]  q;
      logic [FRAC_W-1:0] r;
      logic              inc;
      logic [OUT_W:0]    t;
      q   = v[ST_W-1:FRAC_W];
      r   = v[FRAC_W-1:0];
      inc = (r > {1'b1, {(FRAC_W-1){1'b0}}})
         || ((r == {1'b1, {(FRAC_W-1){1'b0}}}) && q[0]);
      t   = {q[OUT_W-1], q} + (OUT_W+1)'(inc);
      if (t[OUT_W] != t[OUT_W-1]) begin
         return {1'b0, {(OUT_W-1){1'b1}}};
      end
      return t[OUT_W-1:0];
   endfunction

   logic [1:0]              state_ff;
   logic [3:0]              ph_ff;
   logic [CH_W-1:0]         ch_ff;
   frame_type               frm_ff;
   logic [MEM_DEPTH-1:0]    vld_ff;
   logic                    vld_rd_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic [ST_W-1:0]         y_ff;
   logic [ST_W:0]           diff_ff;
   logic [ST_W-1:0]         lp_ff;
   logic [OUT_W-1:0]        coll_ff [NUM_CHANNELS];
   logic                    rsp_valid_ff;
   logic [DEV_W-1:0]        rsp_dev_ff;
   logic [NUM_FIELD_CH-1:0][OUT_W-1:0] rsp_data_ff;

   logic [MEM_AW-1:0]       addr;
   logic                    rd_en;
   logic                    wr_en;
   logic [MEM_W-1:0]        rd_data;
   logic [MEM_W-1:0]        wr_data;
   logic [ST_W-1:0]         x48;
   logic [ST_W-1:0]         px;
   logic [ST_W-1:0]         py;
   logic [ST_W-1:0]         pl;
   logic [ST_W-1:0]         hp;
   logic [ST_W-1:0]         fin;
   logic signed [MUL_S_W-1:0] mul_s;
   logic signed [COEF_W-1:0]  mul_c;
   logic signed [MUL_R_W-1:0] mul_res;
   logic [ACC_W-1:0]        res_ext;
   logic [ACC_W-1:0]        lp_sum;
   logic                    last_ch;
   logic                    out_free;

   assign addr = MEM_AW'(frm_ff.device) * MEM_AW'(NUM_CHANNELS) + MEM_AW'(ch_ff);
   assign rd_en = (state_ff == ST_RUN) && (ph_ff == PH_READ);
   assign wr_en = (state_ff == ST_RUN) && (ph_ff == PH_WRITE);

   assign x48 = {{(ST_W-SMP_W-FRAC_W){frm_ff.smp[ch_ff][SMP_W-1]}},
                 frm_ff.smp[ch_ff], {FRAC_W{1'b0}}};

   // Entries never written since reset read as zero state.
   assign px = vld_rd_ff ? rd_data[X_LSB +: ST_W] : '0;
   assign py = vld_rd_ff ? rd_data[Y_LSB +: ST_W] : '0;
   assign pl = vld_rd_ff ? rd_data[0 +: ST_W] : '0;

   assign hp      = cfg.hp_en ? y_ff : x48;
   assign fin     = cfg.lp_en ? lp_ff : hp;
   assign wr_data = {x48, y_ff, lp_ff};
   assign res_ext = {{(ACC_W-MUL_R_W){mul_res[MUL_R_W-1]}}, mul_res};
   assign lp_sum  = {{(ACC_W-ST_W){pl[ST_W-1]}}, pl} + res_ext;
   assign last_ch = (ch_ff == CH_W'(NUM_CHANNELS - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fr_ready = (state_ff == ST_IDLE);

   always_comb begin
      unique case (ph_ff)
         PH_MUL_B0: begin
            mul_s = $signed({{(MUL_S_W-ST_W){x48[ST_W-1]}}, x48});
            mul_c = cfg.b0;
         end
         PH_MUL_B1: begin
            mul_s = $signed({{(MUL_S_W-ST_W){px[ST_W-1]}}, px});
            mul_c = cfg.b1;
         end
         PH_MUL_A1: begin
            mul_s = $signed({{(MUL_S_W-ST_W){py[ST_W-1]}}, py});
            mul_c = cfg.a1;
         end
         default: begin
            mul_s = $signed({{(MUL_S_W-ST_W-1){diff_ff[ST_W]}}, diff_ff});
            mul_c = $signed({1'b0, cfg.alpha});
         end
      endcase
   end

   dhf_mulq u_mulq (
      .clock (clock),
      .s     (mul_s),
      .c     (mul_c),
      .res   (mul_res)
   );

   dhf_ram #(
      .WIDTH (MEM_W),
      .DEPTH (MEM_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= PH_READ;
         ch_ff        <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (fr_valid) begin
                  state_ff <= ST_RUN;
                  ph_ff    <= PH_READ;
                  ch_ff    <= '0;
               end
            end
            ST_RUN: begin
               if (ph_ff == PH_WRITE) begin
                  vld_ff[addr] <= 1'b1;
                  ph_ff        <= PH_READ;
                  if (last_ch) begin
                     state_ff <= ST_DONE;
                  end else begin
                     ch_ff <= ch_ff + CH_W'(1);
                  end
               end else begin
                  ph_ff <= ph_ff + 4'd1;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fr_valid && fr_ready) begin
         frm_ff <= fr_data;
      end
      if (state_ff == ST_RUN) begin
         unique case (ph_ff)
            PH_READ:   vld_rd_ff <= vld_ff[addr];
            PH_ACC_B0: acc_ff <= res_ext;
            PH_ACC_B1: acc_ff <= acc_ff + res_ext;
            PH_ACC_A1: acc_ff <= acc_ff - res_ext;
            PH_SAT_HP: y_ff <= sat48(acc_ff);
            PH_DIFF:   diff_ff <= {hp[ST_W-1], hp} - {pl[ST_W-1], pl};
            PH_ACC_LP: lp_ff <= sat48(lp_sum);
            PH_WRITE:  coll_ff[ch_ff] <= to_count(fin);
            default: begin
            end
         endcase
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_dev_ff <= frm_ff.device;
         for (int k = 0; k < NUM_FIELD_CH; k++) begin
            if (k < NUM_CHANNELS) begin
               rsp_data_ff[k] <= coll_ff[k];
            end else begin
               rsp_data_ff[k] <= '0;
            end
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_device = rsp_dev_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### hdl/decimating_hpf_ema_channel_filter.sv
// ----------------------------------------------------------------------------
// Decimating highpass / EMA channel filter
// Keeps one frame in N per device, then filters every channel through a
// first-order IIR highpass and an exponential lowpass, each of which can be
// bypassed, rounding the result to a saturated 32-bit count.
//
//   Channel   Direction   Handshake                Payload
//   req_      in          req_tvalid/req_tready    tuser device, tdata ch0..ch7
//   rsp_      out         rsp_tvalid/rsp_tready    tuser device, tdata ch0..ch7
//   csr_      in          csr_valid/csr_ready      csr_index, csr_data
//
// A kept frame holds the filter while each channel makes four passes through
// the one shared multiplier, and the lowpass pass waits on the highpass sum.
// Dropped frames reach neither the queue nor the filter, but are taken only
// while the queue has room. A two-word queue sits between the counters and
// the filter, and a result word waits in the output register while the next
// frame is taken. Reset is synchronous; the filter state reads as zero after
// reset through per-entry valid flags, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module decimating_hpf_ema_channel_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample_ch0 .. sample_ch7, 24 bits each
   input  logic [dhf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // device
   input  logic [dhf_pkg::DEV_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_ch0 .. out_ch7, 32 bits each
   output logic [dhf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // out_device
   output logic [dhf_pkg::DEV_W-1:0]         rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dhf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dhf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import dhf_pkg::*;

   cfg_type   cfg_ff;
   logic      push_valid;
   logic      push_ready;
   frame_type push_data;
   logic      fr_valid;
   logic      fr_ready;
   frame_type fr_data;
   logic [NUM_FIELD_CH-1:0][OUT_W-1:0] rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hp_en      <= 1'b1;
         cfg_ff.lp_en      <= 1'b1;
         cfg_ff.dec_factor <= DEC_W'(1);
         cfg_ff.b0         <= 32'sd1072899173;
         cfg_ff.b1         <= -32'sd1072899173;
         cfg_ff.a1         <= -32'sd1072056522;
         cfg_ff.alpha      <= 31'd500913446;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_HP_ENABLE:  cfg_ff.hp_en      <= csr_data[0];
            REG_LP_ENABLE:  cfg_ff.lp_en      <= csr_data[0];
            REG_DEC_FACTOR: cfg_ff.dec_factor <= csr_data[DEC_W-1:0];
            REG_HP_B0:      cfg_ff.b0         <= $signed(csr_data[COEF_W-1:0]);
            REG_HP_B1:      cfg_ff.b1         <= $signed(csr_data[COEF_W-1:0]);
            REG_HP_A1:      cfg_ff.a1         <= $signed(csr_data[COEF_W-1:0]);
            REG_LP_ALPHA:   cfg_ff.alpha      <= csr_data[ALPHA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   dhf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .dec_factor (cfg_ff.dec_factor),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_device (req_tuser),
      .req_data   (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   dhf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   dhf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fr_valid   (fr_valid),
      .fr_ready   (fr_ready),
      .fr_data    (fr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_device (rsp_tuser),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = rsp_data;

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the decimating highpass / EMA channel filter
// Drives multichannel frames against a bit-exact predictor of the decimation
// counters, the Q2.30 highpass and lowpass stages and the rounded output.
// A short table of directed frames and register writes comes first. Random
// phases with fresh register settings and random stalls on both ports follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import dhf_pkg::*;

   localparam int          SETTLE_CYCLES    = 300;
   localparam int unsigned CYCLE_LIMIT      = 1_000_000;
   localparam int          RANDOM_PHASES    = 12;
   localparam int          FRAMES_PER_PHASE = 95;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   localparam logic [SMP_W-1:0] SMP_MAX = 24'h7F_FFFF;
   localparam logic [SMP_W-1:0] SMP_MIN = 24'h80_0000;

   localparam logic [31:0] COEF_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] COEF_MIN   = 32'h8000_0000;
   localparam logic [31:0] ALPHA_ONE  = 32'h4000_0000;
   localparam logic [31:0] ALPHA_TOP  = 32'h7FFF_FFFF;
   localparam logic [31:0] B0_RESET   = 32'sd1072899173;
   localparam logic [31:0] B1_RESET   = -32'sd1072899173;
   localparam logic [31:0] A1_RESET   = -32'sd1072056522;
   localparam logic [31:0] ALPHA_RESET = 32'd500913446;

   typedef logic signed [95:0] wide_t;

   localparam wide_t ST_MAX  = 96'sh7FFF_FFFF_FFFF;
   localparam wide_t ST_MIN  = -ST_MAX - 96'sd1;
   localparam wide_t CNT_MAX = 96'sh7FFF_FFFF;
   localparam wide_t CNT_MIN = -CNT_MAX - 96'sd1;

   typedef enum logic [1:0] {ROW_FRAME, ROW_REG} row_kind_e;
   typedef enum logic [1:0] {CHK_MODEL, CHK_ZERO, CHK_ECHO} check_e;

   typedef struct {
      row_kind_e              kind;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      logic [DEV_W-1:0]       dev;
      logic [REQ_DATA_W-1:0]  samples;
      check_e                 check;
   } row_t;

   typedef struct {
      logic [DEV_W-1:0]      device;
      logic [RSP_DATA_W-1:0] counts;
   } out_word_t;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [DEV_W-1:0]        req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [DEV_W-1:0]        rsp_tuser;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   // Filter state and register copy of the predictor.
   cfg_type                 filt_cfg;
   logic [DEC_W-1:0]        frame_cnt [NUM_DEVICES] = '{default: '0};
   logic signed [ST_W-1:0]  prev_in [NUM_DEVICES][NUM_CHANNELS] = '{default: '{default: '0}};
   logic signed [ST_W-1:0]  prev_hp [NUM_DEVICES][NUM_CHANNELS] = '{default: '{default: '0}};
   logic signed [ST_W-1:0]  prev_lp [NUM_DEVICES][NUM_CHANNELS] = '{default: '{default: '0}};

   out_word_t               expected_frames [$];
   int                      mismatch_count = 0;
   int unsigned             cycle_count = 0;
   bit                      idling_on = 1'b1;
   int                      rsp_hold = 0;

   decimating_hpf_ema_channel_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Exact product with a Q2.30 coefficient, rounded half to even.
   function automatic wide_t coef_mul(wide_t s, wide_t c);
      wide_t p, q;
      p = s * c;
      q = p >>> 30;
      if (p[29:0] > 30'h2000_0000 || (p[29:0] == 30'h2000_0000 && q[0])) q = q + 96'sd1;
      return q;
   endfunction

   function automatic wide_t clamp_state(wide_t v);
      if (v > ST_MAX) return ST_MAX;
      if (v < ST_MIN) return ST_MIN;
      return v;
   endfunction

   function automatic logic [OUT_W-1:0] round_count(wide_t v);
      wide_t q;
      q = v >>> FRAC_W;
      if (v[15:0] > 16'h8000 || (v[15:0] == 16'h8000 && q[0])) q = q + 96'sd1;
      if (q > CNT_MAX) return CNT_MAX[OUT_W-1:0];
      if (q < CNT_MIN) return CNT_MIN[OUT_W-1:0];
      return q[OUT_W-1:0];
   endfunction

   // Advances the decimation counter and, on a kept frame, the filter state.
   function automatic bit filter_frame(input logic [DEV_W-1:0] dev,
                                       input logic [REQ_DATA_W-1:0] samples,
                                       output logic [RSP_DATA_W-1:0] counts);
      wide_t x, y, src, lp, fin, b0w, b1w, a1w, aw, pin, php, plp;
      counts = '0;
      frame_cnt[dev] = frame_cnt[dev] + 16'd1;
      if (frame_cnt[dev] < filt_cfg.dec_factor) return 1'b0;
      frame_cnt[dev] = '0;
      b0w = $signed(filt_cfg.b0);
      b1w = $signed(filt_cfg.b1);
      a1w = $signed(filt_cfg.a1);
      aw  = {65'd0, filt_cfg.alpha};
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         x = $signed(samples[c*SMP_W +: SMP_W]);
         x = x * 96'sd65536;
         pin = prev_in[dev][c];
         php = prev_hp[dev][c];
         plp = prev_lp[dev][c];
         y = clamp_state(coef_mul(x, b0w) + coef_mul(pin, b1w) - coef_mul(php, a1w));
         prev_in[dev][c] = x[ST_W-1:0];
         prev_hp[dev][c] = y[ST_W-1:0];
         src = filt_cfg.hp_en ? y : x;
         lp = clamp_state(plp + coef_mul(src - plp, aw));
         prev_lp[dev][c] = lp[ST_W-1:0];
         fin = filt_cfg.lp_en ? lp : src;
         counts[c*OUT_W +: OUT_W] = round_count(fin);
      end
      return 1'b1;
   endfunction

   function automatic void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_HP_ENABLE:  filt_cfg.hp_en = val[0];
         REG_LP_ENABLE:  filt_cfg.lp_en = val[0];
         REG_DEC_FACTOR: filt_cfg.dec_factor = val[DEC_W-1:0];
         REG_HP_B0:      filt_cfg.b0 = val;
         REG_HP_B1:      filt_cfg.b1 = val;
         REG_HP_A1:      filt_cfg.a1 = val;
         REG_LP_ALPHA:   filt_cfg.alpha = val[ALPHA_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic row_t frame_row(logic [DEV_W-1:0] dev, logic [REQ_DATA_W-1:0] samples,
                                      check_e check);
      row_t r;
      r.kind = ROW_FRAME;
      r.reg_idx = '0;
      r.reg_val = '0;
      r.dev = dev;
      r.samples = samples;
      r.check = check;
      return r;
   endfunction

   function automatic row_t reg_row(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      row_t r;
      r = frame_row('0, '0, CHK_MODEL);
      r.kind = ROW_REG;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   function automatic logic [31:0] pick_coef(logic [31:0] nominal);
      case ($urandom_range(0, 3))
         0: return nominal;
         1: return $urandom;
         2: begin
            case ($urandom_range(0, 2))
               0: return COEF_MAX;
               1: return COEF_MIN;
               default: return '0;
            endcase
         end
         default: return nominal + $urandom_range(0, 2_000_000) - 32'd1_000_000;
      endcase
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_samples();
      logic [REQ_DATA_W-1:0] s;
      logic [31:0]           r;
      for (int c = 0; c < NUM_FIELD_CH; c++) begin
         r = $urandom;
         case ($urandom_range(0, 5))
            0, 1, 2: s[c*SMP_W +: SMP_W] = r[SMP_W-1:0];
            3: begin
               case (r[1:0])
                  2'd0: s[c*SMP_W +: SMP_W] = SMP_MAX;
                  2'd1: s[c*SMP_W +: SMP_W] = SMP_MIN;
                  2'd2: s[c*SMP_W +: SMP_W] = '0;
                  default: s[c*SMP_W +: SMP_W] = '1;
               endcase
            end
            default: s[c*SMP_W +: SMP_W] = 24'($urandom_range(0, 4000)) - 24'd2000;
         endcase
      end
      return s;
   endfunction

   // Called at a falling edge; returns at the falling edge after the write.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      set_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   // with the valid still high so back-to-back words need no bubble.
   task automatic send_frame(input logic [DEV_W-1:0] dev, input logic [REQ_DATA_W-1:0] samples,
                             input check_e check);
      logic [RSP_DATA_W-1:0] counts;
      out_word_t             word;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= dev;
      req_tdata  <= samples;
      do @(posedge clock); while (!req_tready);
      if (filter_frame(dev, samples, counts)) begin
         word.device = dev;
         case (check)
            CHK_ZERO: word.counts = '0;
            CHK_ECHO: begin
               for (int c = 0; c < NUM_FIELD_CH; c++)
                  word.counts[c*OUT_W +: OUT_W] = {{(OUT_W-SMP_W){samples[c*SMP_W+SMP_W-1]}},
                                                   samples[c*SMP_W +: SMP_W]};
            end
            default: word.counts = counts;
         endcase
         expected_frames.push_back(word);
      end
      @(negedge clock);
   endtask

   // Waits out every expected word, then a further settling wait with the request port idle.
   task automatic drain_filter();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (idling_on && $urandom_range(0, 7) == 0) rsp_hold <= $urandom_range(1, 12);
      end
   end

   always @(posedge clock) begin : check_output
      out_word_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected output word, device %0d", $time, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_frames.pop_front();
            if (rsp_tuser !== want.device) begin
               $display("%0t: out_device expected %0d actual %0d", $time, want.device, rsp_tuser);
               mismatch_count++;
            end
            for (int c = 0; c < NUM_FIELD_CH; c++) begin
               if (rsp_tdata[c*OUT_W +: OUT_W] !== want.counts[c*OUT_W +: OUT_W]) begin
                  $display("%0t: out_ch%0d expected %0d actual %0d", $time, c,
                           $signed(want.counts[c*OUT_W +: OUT_W]),
                           $signed(rsp_tdata[c*OUT_W +: OUT_W]));
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL decimating_hpf_ema_channel_filter");
         $finish;
      end
   end

   initial begin : stimulus
      row_t                  plan [$];
      logic [REQ_DATA_W-1:0] all_max, all_min, alt, mixed;
      logic [DEC_W-1:0]      dec;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;

      filt_cfg.hp_en      = 1'b1;
      filt_cfg.lp_en      = 1'b1;
      filt_cfg.dec_factor = 16'd1;
      filt_cfg.b0         = B0_RESET;
      filt_cfg.b1         = B1_RESET;
      filt_cfg.a1         = A1_RESET;
      filt_cfg.alpha      = ALPHA_RESET[ALPHA_W-1:0];

      all_max = {NUM_FIELD_CH{SMP_MAX}};
      all_min = {NUM_FIELD_CH{SMP_MIN}};
      alt     = {(NUM_FIELD_CH/2){SMP_MIN, SMP_MAX}};
      mixed   = {24'h40_0000, 24'hED_CBA9, 24'h12_3456, SMP_MIN,
                 SMP_MAX, 24'h00_0000, 24'hFF_FFFF, 24'h00_0001};

      // After reset a zero frame must come out as zero on every channel.
      plan.push_back(frame_row(2'd0, '0, CHK_ZERO));
      plan.push_back(frame_row(2'd1, all_max, CHK_MODEL));
      plan.push_back(frame_row(2'd1, all_min, CHK_MODEL));
      plan.push_back(frame_row(2'd2, alt, CHK_MODEL));
      plan.push_back(frame_row(2'd3, mixed, CHK_MODEL));
      // With both stages bypassed the counts pass straight through.
      plan.push_back(reg_row(REG_HP_ENABLE, 32'd0));
      plan.push_back(reg_row(REG_LP_ENABLE, 32'd0));
      plan.push_back(frame_row(2'd0, all_max, CHK_ECHO));
      plan.push_back(frame_row(2'd1, all_min, CHK_ECHO));
      plan.push_back(frame_row(2'd3, mixed, CHK_ECHO));
      plan.push_back(reg_row(REG_HP_ENABLE, 32'd1));
      plan.push_back(frame_row(2'd2, all_max, CHK_MODEL));
      plan.push_back(frame_row(2'd2, all_min, CHK_MODEL));
      plan.push_back(reg_row(REG_HP_ENABLE, 32'd0));
      plan.push_back(reg_row(REG_LP_ENABLE, 32'd1));
      plan.push_back(frame_row(2'd3, all_max, CHK_MODEL));
      plan.push_back(reg_row(REG_DEC_FACTOR, 32'd3));
      plan.push_back(frame_row(2'd0, mixed, CHK_MODEL));
      plan.push_back(frame_row(2'd0, alt, CHK_MODEL));
      plan.push_back(frame_row(2'd0, all_max, CHK_MODEL));
      plan.push_back(frame_row(2'd1, all_min, CHK_MODEL));
      // A zero factor keeps every frame.
      plan.push_back(reg_row(REG_DEC_FACTOR, 32'd0));
      plan.push_back(frame_row(2'd2, alt, CHK_MODEL));
      // Extreme coefficients drive the state and the output into saturation.
      plan.push_back(reg_row(REG_HP_ENABLE, 32'd1));
      plan.push_back(reg_row(REG_HP_B0, COEF_MAX));
      plan.push_back(reg_row(REG_HP_B1, COEF_MIN));
      plan.push_back(reg_row(REG_HP_A1, COEF_MIN));
      plan.push_back(reg_row(REG_LP_ALPHA, ALPHA_TOP));
      plan.push_back(reg_row(REG_UNMAPPED, 32'hFFFF_FFFF));
      plan.push_back(frame_row(2'd3, all_max, CHK_MODEL));
      plan.push_back(frame_row(2'd3, all_min, CHK_MODEL));
      plan.push_back(frame_row(2'd3, all_max, CHK_MODEL));
      plan.push_back(frame_row(2'd3, all_max, CHK_MODEL));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            drain_filter();
            write_register(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            send_frame(plan[i].dev, plan[i].samples, plan[i].check);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_filter();
         // The closing phases run with both ports at full rate.
         idling_on = (phase < RANDOM_PHASES - 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
         case ($urandom_range(0, 9))
            0: dec = 16'd0;
            1, 2, 3: dec = 16'd1;
            9: dec = 16'hFFFF;
            default: dec = 16'($urandom_range(2, 5));
         endcase
         write_register(REG_HP_ENABLE, 32'($urandom_range(0, 1)));
         write_register(REG_LP_ENABLE, 32'($urandom_range(0, 1)));
         write_register(REG_DEC_FACTOR, {16'($urandom), dec});
         write_register(REG_HP_B0, pick_coef(B0_RESET));
         write_register(REG_HP_B1, pick_coef(B1_RESET));
         write_register(REG_HP_A1, pick_coef(A1_RESET));
         case ($urandom_range(0, 3))
            0: write_register(REG_LP_ALPHA, ALPHA_RESET);
            1: write_register(REG_LP_ALPHA, $urandom_range(0, ALPHA_ONE));
            2: write_register(REG_LP_ALPHA, ($urandom_range(0, 1) != 0) ? ALPHA_ONE : ALPHA_TOP);
            default: write_register(REG_LP_ALPHA, $urandom);
         endcase
         write_register(REG_UNMAPPED, $urandom);
         repeat (FRAMES_PER_PHASE)
            send_frame(DEV_W'($urandom_range(0, NUM_DEVICES - 1)), random_samples(), CHK_MODEL);
      end

      drain_filter();
      if (mismatch_count == 0) begin
         $display("PASS decimating_hpf_ema_channel_filter");
      end else begin
         $display("FAIL decimating_hpf_ema_channel_filter");
      end
      $finish;
   end

endmodule

### decimating_hpf_ema_channel_filter.f
hdl/dhf_pkg.sv
hdl/dhf_ram.sv
hdl/dhf_queue.sv
hdl/dhf_front.sv
hdl/dhf_mulq.sv
hdl/dhf_back.sv
hdl/decimating_hpf_ema_channel_filter.sv
test/tb.sv
